// ----- sv/cbws_pkg.sv -----
// cbws_pkg: shared types and constants of the cut boundary weight sum block
// request and result payloads, edge record, mark write bundle and function codes
// no dependencies
package cbws_pkg;

    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W    = 28;
    localparam int TOL_W    = 16;
    localparam int FUNC_W   = 2;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MEMBER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd16;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [NODE_W-1:0]   end_a;
        logic [NODE_W-1:0]   end_b;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [NODE_W-1:0]   set_node;
        logic                last;
        logic [SUM_W-1:0]    expected_sum;
    } cbws_req_t;

    typedef struct packed {
        logic [SUM_W-1:0] boundary_sum;
        logic             mismatch;
        logic             edge_overflow;
    } cbws_res_t;

    typedef struct packed {
        logic [NODE_W-1:0]   end_a;
        logic [NODE_W-1:0]   end_b;
        logic [WEIGHT_W-1:0] weight;
    } cbws_edge_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] node;
        logic              mark;
    } cbws_mark_wr_t;

endpackage

// ----- sv/cbws_edge_store.sv -----
// cbws_edge_store: edge list memory with fill count and drop flag
// one write port for loads, one registered read port for the scan
// depends on cbws_pkg
module cbws_edge_store #(
    parameter int MAX_EDGES = 4096,
    localparam int CNT_W   = $clog2(MAX_EDGES + 1),
    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_en,
    input  cbws_pkg::cbws_edge_t load_edge,
    input  logic                clear_en,
    input  logic                rd_en,
    input  logic [CNT_W-1:0]    rd_idx,
    output cbws_pkg::cbws_edge_t rd_edge,
    output logic [CNT_W-1:0]    edge_count,
    output logic                overflow
);
    import cbws_pkg::*;

    cbws_edge_t       edge_mem [MAX_EDGES];
    cbws_edge_t       rd_edge_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             room;
    logic             wr_en;

    // fill count and drop flag
    always_comb
    begin
        room       = (count_reg < CNT_W'(MAX_EDGES));
        wr_en      = load_en && room;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (clear_en)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (load_en)
        begin
            if (room)
                count_next = count_reg + CNT_W'(1);
            else
                ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            edge_mem[count_reg[EDGE_AW-1:0]] <= load_edge;
        if (rd_en)
            rd_edge_reg <= edge_mem[rd_idx[EDGE_AW-1:0]];
    end

    assign rd_edge    = rd_edge_reg;
    assign edge_count = count_reg;
    assign overflow   = ovf_reg;

endmodule

// ----- sv/cbws_mark_store.sv -----
// cbws_mark_store: one membership mark per node
// one write port, two registered read ports for both ends of an edge
// depends on cbws_pkg
module cbws_mark_store #(
    parameter int MARK_DEPTH = 1024,
    localparam int MARK_AW = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1
) (
    input  logic                    clk,
    input  cbws_pkg::cbws_mark_wr_t wr,
    input  logic [cbws_pkg::NODE_W-1:0] rd_node_a,
    input  logic [cbws_pkg::NODE_W-1:0] rd_node_b,
    output logic                    mark_a,
    output logic                    mark_b
);
    import cbws_pkg::*;

    logic mark_mem [MARK_DEPTH];
    logic mark_a_reg;
    logic mark_b_reg;

    // write and two reads, read data registered
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mark_mem[wr.node[MARK_AW-1:0]] <= wr.mark;
        mark_a_reg <= mark_mem[rd_node_a[MARK_AW-1:0]];
        mark_b_reg <= mark_mem[rd_node_b[MARK_AW-1:0]];
    end

    assign mark_a = mark_a_reg;
    assign mark_b = mark_b_reg;

endmodule

// ----- sv/cut_boundary_weight_sum.sv -----
// cut_boundary_weight_sum: top level, request decode, edge scan, sum and compare
// depends on cbws_pkg, cbws_edge_store, cbws_mark_store
//
// Edge loads, clears and set members without last are taken one per cycle with
// busy low. A member with last set starts a scan that reads every stored edge
// from the edge memory, one edge per cycle, then checks both end marks in the
// mark memory; the result strobe done comes once the scan has drained and is high for one
// cycle only, since the receiver cannot stall. After the result the mark memory
// is cleared one node per cycle over the mark depth, which is MAX_NODES capped
// at 1024, and busy stays high until that pass ends. The same clearing pass runs
// after reset before the first request is taken. Tolerance writes are taken at
// any time and are meant to come while the block is idle.
module cut_boundary_weight_sum #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cbws_pkg::cbws_req_t  req,
    output logic                 done,
    output cbws_pkg::cbws_res_t  result,
    input  logic                 cfg_we,
    input  logic [cbws_pkg::TOL_W-1:0] cfg_wdata
);
    import cbws_pkg::*;

    localparam int MARK_DEPTH = (MAX_NODES < 1024) ? MAX_NODES : 1024;
    localparam int MARK_AW    = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
    localparam int CNT_W      = $clog2(MAX_EDGES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [MARK_AW-1:0]  sweep_reg, sweep_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [SUM_W-1:0]    exp_reg, exp_next;
    logic                p1_valid_reg, p1_valid_next;
    logic                p2_valid_reg;
    logic                a_ok_reg, b_ok_reg;
    logic [WEIGHT_W-1:0] w2_reg;
    logic                done_reg, done_next;
    cbws_res_t           result_reg, result_next;
    logic [TOL_W-1:0]    tol_reg;

    logic                accept;
    logic                edge_rd_en;
    cbws_edge_t          load_edge;
    cbws_edge_t          rd_edge;
    logic [CNT_W-1:0]    edge_count;
    logic                overflow;
    cbws_mark_wr_t       mark_wr;
    logic                mark_a, mark_b;
    logic                a_ok, b_ok;
    logic                crosses;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    diff;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign load_edge.end_a  = req.end_a;
    assign load_edge.end_b  = req.end_b;
    assign load_edge.weight = req.edge_weight;

    cbws_edge_store #(
        .MAX_EDGES (MAX_EDGES)
    ) u_edges (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (accept && (req.func == FUNC_LOAD)),
        .load_edge  (load_edge),
        .clear_en   (accept && (req.func == FUNC_CLEAR)),
        .rd_en      (edge_rd_en),
        .rd_idx     (scan_idx_reg),
        .rd_edge    (rd_edge),
        .edge_count (edge_count),
        .overflow   (overflow)
    );

    cbws_mark_store #(
        .MARK_DEPTH (MARK_DEPTH)
    ) u_marks (
        .clk       (clk),
        .wr        (mark_wr),
        .rd_node_a (rd_edge.end_a),
        .rd_node_b (rd_edge.end_b),
        .mark_a    (mark_a),
        .mark_b    (mark_b)
    );

    // end range checks on the edge just read
    assign a_ok = (32'(rd_edge.end_a) < MAX_NODES);
    assign b_ok = (32'(rd_edge.end_b) < MAX_NODES);

    // crossing test and saturating accumulate
    assign crosses  = (mark_a && a_ok_reg) != (mark_b && b_ok_reg);
    assign sum_wide = {1'b0, acc_reg} + (SUM_W + 1)'(w2_reg);

    // distance to the expected sum
    assign diff = (acc_reg >= exp_reg) ? (acc_reg - exp_reg) : (exp_reg - acc_reg);

    // mark writes: members while idle, zeros during the clearing pass
    always_comb
    begin
        mark_wr.en   = 1'b0;
        mark_wr.node = req.set_node;
        mark_wr.mark = 1'b1;
        if (state_reg == ST_CLEAR)
        begin
            mark_wr.en   = 1'b1;
            mark_wr.node = NODE_W'(sweep_reg);
            mark_wr.mark = 1'b0;
        end
        else if (accept && (req.func == FUNC_MEMBER) &&
                 (32'(req.set_node) < MAX_NODES))
        begin
            mark_wr.en = 1'b1;
        end
    end

    // control sequence
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        sweep_next    = sweep_reg;
        acc_next      = acc_reg;
        exp_next      = exp_reg;
        p1_valid_next = 1'b0;
        edge_rd_en    = 1'b0;
        done_next     = 1'b0;
        result_next   = result_reg;

        if (p2_valid_reg && crosses)
            acc_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.func == FUNC_MEMBER) && req.last)
                begin
                    state_next    = ST_SCAN;
                    scan_idx_next = '0;
                    acc_next      = '0;
                    exp_next      = req.expected_sum;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg < edge_count)
                begin
                    edge_rd_en    = 1'b1;
                    p1_valid_next = 1'b1;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    done_next                 = 1'b1;
                    result_next.boundary_sum  = acc_reg;
                    result_next.mismatch      = (diff > SUM_W'(tol_reg));
                    result_next.edge_overflow = overflow;
                    sweep_next                = '0;
                    state_next                = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (sweep_reg == MARK_AW'(MARK_DEPTH - 1))
                    state_next = ST_IDLE;
                else
                    sweep_next = sweep_reg + MARK_AW'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            sweep_reg    <= '0;
            scan_idx_reg <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            tol_reg      <= TOL_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            scan_idx_reg <= scan_idx_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p1_valid_reg;
            done_reg     <= done_next;
            if (cfg_we)
                tol_reg <= cfg_wdata;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        exp_reg    <= exp_next;
        a_ok_reg   <= a_ok;
        b_ok_reg   <= b_ok;
        w2_reg     <= rd_edge.weight;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- sv/cbws_checker.sv -----
// cbws_checker: port level checks on the cut boundary weight sum block
// bound to cut_boundary_weight_sum; depends on cbws_pkg
module cbws_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input cbws_pkg::cbws_req_t req,
    input logic                done
);
    import cbws_pkg::*;

    logic member_last_req;
    logic other_req;

    assign member_last_req = start && !busy && (req.func == FUNC_MEMBER) && req.last;
    assign other_req       = start && !busy && !((req.func == FUNC_MEMBER) && req.last);

    // a result only shows while the block is working
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    // the mark clearing pass keeps the block busy after a result
    a_done_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (busy && !done))
        else $error("block idle or strobing again right after a result");

    // a final member starts the scan
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        member_last_req |=> busy)
        else $error("final member did not start a scan");

    // loads, clears and plain members never stall the block
    a_other_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        other_req |=> (!busy && !done))
        else $error("single cycle request made the block busy");

endmodule

bind cut_boundary_weight_sum cbws_checker u_cbws_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done)
);
